// ===== rtl/core/atapio_pkg.sv =====
// Package for the ATA PIO task-file disk: sizes, register offsets, command
// and status codes, and the types used by the control logic and the top level.
// Depends on nothing.
package atapio_pkg;

	localparam int DISK_SECTORS     = 64;
	localparam int WORDS_PER_SECTOR = 256;
	localparam int STORE_WORDS      = DISK_SECTORS * WORDS_PER_SECTOR;
	localparam int STORE_AW         = $clog2(STORE_WORDS);
	localparam int WORD_W           = 16;
	localparam int WPOS_W           = $clog2(WORDS_PER_SECTOR);
	localparam int LBA_W            = 28;
	localparam int LEFT_W           = 9;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [7:0] CMD_READ  = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;
	localparam logic [7:0] CMD_FLUSH = 8'hE7;

	localparam logic [7:0] ERR_IDNF = 8'h10;
	localparam logic [7:0] ERR_ABRT = 8'h04;

	localparam logic [7:0] STAT_DRDY = 8'h40;
	localparam logic [7:0] STAT_DRQ  = 8'h08;
	localparam logic [7:0] STAT_ERR  = 8'h01;

	localparam logic [7:0] DRIVE_RESET = 8'hA0;
	localparam logic [7:0] COUNT_RESET = 8'h01;

	typedef enum logic [2:0] {
		REG_DATA,
		REG_ERROR,
		REG_COUNT,
		REG_LBA_LOW,
		REG_LBA_MID,
		REG_LBA_HIGH,
		REG_DRIVE,
		REG_STATUS
	} reg_off_t;

	typedef enum logic [1:0] {
		XFER_IDLE,
		XFER_READ,
		XFER_WRITE
	} xfer_mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic                rd;
		logic                wr;
		logic [STORE_AW-1:0] addr;
		logic [WORD_W-1:0]   wdata;
	} ram_req_t;

endpackage

// ===== rtl/core/atapio_ram.sv =====
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module atapio_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/core/atapio_ctrl.sv =====
// Task-file register bank and transfer bookkeeping of the ATA PIO disk.
// Depends on atapio_pkg; drives the word-store requests.
module atapio_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic                         kind,
	input  atapio_pkg::reg_off_t         reg_offset,
	input  logic [atapio_pkg::WORD_W-1:0] write_data,
	output atapio_pkg::ram_req_t         req,
	output logic [atapio_pkg::WORD_W-1:0] reg_rdata
);
	import atapio_pkg::*;

	logic [7:0]        low_q, mid_q, high_q, drive_q, count_q, err_q;
	logic              serr_q;
	xfer_mode_t        mode_q;
	logic [WPOS_W-1:0] word_q;
	logic [LEFT_W-1:0] left_q;
	logic [LBA_W-1:0]  cur_q;

	logic [LBA_W-1:0]  lba;
	logic [LEFT_W-1:0] nsect;
	logic              range_bad;
	logic              data_rd, data_wr;
	logic [LEFT_W-1:0] left_next;
	logic [7:0]        wbyte;
	logic [7:0]        status;

	always_comb begin
		wbyte     = write_data[7:0];
		lba       = {drive_q[3:0], high_q, mid_q, low_q};
		nsect     = (count_q == 8'd0) ? LEFT_W'(WORDS_PER_SECTOR) : {1'b0, count_q};
		range_bad = ({1'b0, lba} + {{(LBA_W + 1 - LEFT_W){1'b0}}, nsect})
			> (LBA_W + 1)'(DISK_SECTORS);
		data_rd   = acc && (kind == KIND_READ) && (reg_offset == REG_DATA)
			&& (mode_q == XFER_READ);
		data_wr   = acc && (kind == KIND_WRITE) && (reg_offset == REG_DATA)
			&& (mode_q == XFER_WRITE);
		left_next = (left_q != '0) ? left_q - 1'b1 : left_q;
		status    = STAT_DRDY | ((mode_q != XFER_IDLE) ? STAT_DRQ : 8'h00)
			| (serr_q ? STAT_ERR : 8'h00);
		req.rd    = data_rd;
		req.wr    = data_wr;
		req.addr  = STORE_AW'({cur_q, word_q});
		req.wdata = write_data;
	end

	always_comb begin
		reg_rdata = '0;
		if (kind == KIND_READ) begin
			unique case (reg_offset)
				REG_DATA:     reg_rdata = '0;
				REG_ERROR:    reg_rdata = {8'h00, err_q};
				REG_COUNT:    reg_rdata = {8'h00, count_q};
				REG_LBA_LOW:  reg_rdata = {8'h00, low_q};
				REG_LBA_MID:  reg_rdata = {8'h00, mid_q};
				REG_LBA_HIGH: reg_rdata = {8'h00, high_q};
				REG_DRIVE:    reg_rdata = {8'h00, drive_q};
				REG_STATUS:   reg_rdata = {8'h00, status};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			mid_q   <= '0;
			high_q  <= '0;
			drive_q <= DRIVE_RESET;
			count_q <= COUNT_RESET;
			err_q   <= '0;
			serr_q  <= 1'b0;
			mode_q  <= XFER_IDLE;
			word_q  <= '0;
			left_q  <= '0;
			cur_q   <= '0;
		end else if (acc) begin
			if (data_rd || data_wr) begin
				word_q <= word_q + 1'b1;
				if (word_q == {WPOS_W{1'b1}}) begin
					cur_q  <= cur_q + 1'b1;
					left_q <= left_next;
					if (left_next == '0) begin
						mode_q <= XFER_IDLE;
					end
				end
			end
			if (kind == KIND_WRITE) begin
				unique case (reg_offset)
					REG_DATA, REG_ERROR: ;
					REG_COUNT:    count_q <= wbyte;
					REG_LBA_LOW:  low_q   <= wbyte;
					REG_LBA_MID:  mid_q   <= wbyte;
					REG_LBA_HIGH: high_q  <= wbyte;
					REG_DRIVE:    drive_q <= wbyte;
					REG_STATUS: begin
						case (wbyte) inside
							CMD_READ, CMD_WRITE: begin
								if (range_bad) begin
									serr_q <= 1'b1;
									err_q  <= ERR_IDNF;
									mode_q <= XFER_IDLE;
								end else begin
									serr_q <= 1'b0;
									err_q  <= '0;
									cur_q  <= lba;
									left_q <= nsect;
									word_q <= '0;
									mode_q <= (wbyte == CMD_READ) ? XFER_READ : XFER_WRITE;
								end
							end
							CMD_FLUSH: begin
								serr_q <= 1'b0;
								err_q  <= '0;
								mode_q <= XFER_IDLE;
							end
							default: begin
								serr_q <= 1'b1;
								err_q  <= ERR_ABRT;
								mode_q <= XFER_IDLE;
							end
						endcase
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/ata_pio_task_file_disk.sv =====
// ATA PIO task-file disk, device side, with a word store for the sector data.
// Register accesses give their result in the output register in the cycle after
// the item is taken; data-port reads are loaded from the store's read data in ST_READ.
// One item at a time: a new item is taken only in ST_IDLE while the output register
// is empty or being read, so none is taken while a data-port read is in ST_READ.
// Reset restores task-file defaults and clears the transfer state; the store is not cleared.
module ata_pio_task_file_disk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // write_data
	input  logic [3:0]  s_tuser,  // kind, reg_offset
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data
);
	import atapio_pkg::*;

	state_t            state_q, state_d;
	logic              acc;
	ram_req_t          req;
	logic [WORD_W-1:0] reg_rdata;
	logic [WORD_W-1:0] ram_rdata;
	logic              load_direct, load_ram;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;

	assign acc = s_tvalid && s_tready;

	atapio_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.kind       (s_tuser[0]),
		.reg_offset (reg_off_t'(s_tuser[3:1])),
		.write_data (s_tdata),
		.req        (req),
		.reg_rdata  (reg_rdata)
	);

	atapio_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.en    (req.rd || req.wr),
		.we    (req.wr),
		.addr  (req.addr),
		.wdata (req.wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc && req.rd) state_d = ST_READ;
			ST_READ: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
		load_direct = acc && !req.rd;
		load_ram    = (state_q == ST_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_ram) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_data_q <= reg_rdata;
		end else if (load_ram) begin
			out_data_q <= ram_rdata;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("store read pending while the output register is full");

	a_read_enters_wait: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.rd |=> state_q == ST_READ)
		else $error("data-port read did not wait for the store");

	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> out_valid_q)
		else $error("store read data was not loaded into the output register");

	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd && req.wr))
		else $error("store read and write requested in the same cycle");

endmodule

// ===== dv/tb_ata_pio_task_file_disk.sv =====
`timescale 1ns / 1ps
// Testbench for the ATA PIO task-file disk: register and data-port accesses are
// checked against a task-file model kept here. Depends on atapio_pkg and the RTL top.
module tb_ata_pio_task_file_disk;
	import atapio_pkg::*;

	localparam int         STALL_LIMIT  = 4000;
	localparam logic [7:0] CMD_IDENTIFY = 8'hEC;

	typedef struct {
		logic        kind;
		reg_off_t    off;
		logic [15:0] wdata;
		logic [15:0] rdata;
	} bus_access_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [3:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	bus_access_t pending[$];
	logic [15:0] expected_rd[$];
	int          total_items = 0;
	int          n_sent      = 0;
	int          fail_count  = 0;

	logic [7:0]          tf_count;
	logic [7:0]          tf_lba_low;
	logic [7:0]          tf_lba_mid;
	logic [7:0]          tf_lba_high;
	logic [7:0]          tf_drive;
	logic [7:0]          tf_error;
	logic                tf_err_bit;
	xfer_mode_t          tf_mode;
	logic [WPOS_W-1:0]   tf_wpos;
	logic [LEFT_W-1:0]   tf_left;
	logic [LBA_W-1:0]    tf_sector;
	logic [WORD_W-1:0]   disk_words[STORE_WORDS];
	bit                  disk_written[STORE_WORDS];

	ata_pio_task_file_disk DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [35:0] word_index();
		return {8'd0, tf_sector} * 36'(WORDS_PER_SECTOR) + 36'(tf_wpos);
	endfunction

	task automatic step_word();
		tf_wpos = tf_wpos + 1'b1;
		if (tf_wpos == '0) begin
			tf_sector = tf_sector + 1'b1;
			if (tf_left != '0)
				tf_left = tf_left - 1'b1;
			if (tf_left == '0)
				tf_mode = XFER_IDLE;
		end
	endtask

	task automatic run_cmd(input logic [7:0] cmd);
		logic [8:0]  n;
		logic [28:0] lba_end;
		tf_err_bit = 1'b0;
		tf_error   = '0;
		tf_mode    = XFER_IDLE;
		if (cmd == CMD_READ || cmd == CMD_WRITE) begin
			n = (tf_count == '0) ? 9'd256 : {1'b0, tf_count};
			lba_end = {1'b0, tf_drive[3:0], tf_lba_high, tf_lba_mid, tf_lba_low} + 29'(n);
			if (lba_end > 29'(DISK_SECTORS)) begin
				tf_err_bit = 1'b1;
				tf_error   = ERR_IDNF;
			end else begin
				tf_sector = {tf_drive[3:0], tf_lba_high, tf_lba_mid, tf_lba_low};
				tf_left   = n;
				tf_wpos   = '0;
				tf_mode   = (cmd == CMD_READ) ? XFER_READ : XFER_WRITE;
			end
		end else if (cmd != CMD_FLUSH) begin
			tf_err_bit = 1'b1;
			tf_error   = ERR_ABRT;
		end
	endtask

	task automatic disk_access(input logic kind, input reg_off_t off, input logic [15:0] wd,
			output logic [15:0] rd);
		logic [35:0] idx;
		rd  = '0;
		idx = word_index();
		if (kind == KIND_READ) begin
			case (off)
				REG_DATA: begin
					if (tf_mode == XFER_READ) begin
						if (idx < 36'(STORE_WORDS))
							rd = disk_words[int'(idx)];
						step_word();
					end
				end
				REG_ERROR:    rd = {8'd0, tf_error};
				REG_COUNT:    rd = {8'd0, tf_count};
				REG_LBA_LOW:  rd = {8'd0, tf_lba_low};
				REG_LBA_MID:  rd = {8'd0, tf_lba_mid};
				REG_LBA_HIGH: rd = {8'd0, tf_lba_high};
				REG_DRIVE:    rd = {8'd0, tf_drive};
				default: begin
					rd = {8'd0, STAT_DRDY | ((tf_mode != XFER_IDLE) ? STAT_DRQ : 8'd0) |
						(tf_err_bit ? STAT_ERR : 8'd0)};
				end
			endcase
		end else begin
			case (off)
				REG_DATA: begin
					if (tf_mode == XFER_WRITE) begin
						if (idx < 36'(STORE_WORDS)) begin
							disk_words[int'(idx)]   = wd;
							disk_written[int'(idx)] = 1'b1;
						end
						step_word();
					end
				end
				REG_ERROR:    ;
				REG_COUNT:    tf_count    = wd[7:0];
				REG_LBA_LOW:  tf_lba_low  = wd[7:0];
				REG_LBA_MID:  tf_lba_mid  = wd[7:0];
				REG_LBA_HIGH: tf_lba_high = wd[7:0];
				REG_DRIVE:    tf_drive    = wd[7:0];
				default:      run_cmd(wd[7:0]);
			endcase
		end
	endtask

	// A data read that would reach a never-written store word becomes a status read.
	task automatic push_access(input logic kind, input reg_off_t off, input logic [15:0] wd);
		bus_access_t a;
		logic [35:0] idx;
		idx = word_index();
		a.kind  = kind;
		a.off   = off;
		a.wdata = wd;
		if (kind == KIND_READ && off == REG_DATA && tf_mode == XFER_READ &&
				idx < 36'(STORE_WORDS) && !disk_written[int'(idx)])
			a.off = REG_STATUS;
		disk_access(a.kind, a.off, a.wdata, a.rdata);
		pending.push_back(a);
	endtask

	task automatic load_task_file(input logic [27:0] lba, input int n, input logic [3:0] dev_hi);
		push_access(KIND_WRITE, REG_COUNT,    {8'($urandom), 8'(n)});
		push_access(KIND_WRITE, REG_LBA_LOW,  {8'($urandom), lba[7:0]});
		push_access(KIND_WRITE, REG_LBA_MID,  {8'($urandom), lba[15:8]});
		push_access(KIND_WRITE, REG_LBA_HIGH, {8'($urandom), lba[23:16]});
		push_access(KIND_WRITE, REG_DRIVE,    {8'($urandom), dev_hi, lba[27:24]});
	endtask

	task automatic transfer(input logic [7:0] cmd, input int lba, input int n);
		logic k;
		int   stop_at;
		k       = (cmd == CMD_WRITE) ? KIND_WRITE : KIND_READ;
		stop_at = ($urandom_range(99) < 5) ? int'($urandom_range(n * WORDS_PER_SECTOR - 1)) : -1;
		load_task_file(28'(lba), n, 4'($urandom));
		push_access(KIND_WRITE, REG_STATUS, {8'($urandom), cmd});
		for (int w = 0; w < n * WORDS_PER_SECTOR; w++) begin
			if (w == stop_at) begin
				push_access(KIND_WRITE, REG_STATUS, {8'($urandom), CMD_FLUSH});
				break;
			end
			if ($urandom_range(99) < 4)
				push_access(KIND_READ, reg_off_t'($urandom_range(1, 7)), 16'($urandom));
			push_access(k, REG_DATA, 16'($urandom));
		end
		push_access(KIND_READ, REG_STATUS, 16'($urandom));
	endtask

	initial begin
		int          choice;
		int          lba;
		int          n;
		int          full_q[$];
		logic        kind;
		reg_off_t    off;
		logic [15:0] wd;

		tf_count    = COUNT_RESET;
		tf_lba_low  = '0;
		tf_lba_mid  = '0;
		tf_lba_high = '0;
		tf_drive    = DRIVE_RESET;
		tf_error    = '0;
		tf_err_bit  = 1'b0;
		tf_mode     = XFER_IDLE;
		tf_wpos     = '0;
		tf_left     = '0;
		tf_sector   = '0;

		for (int i = 0; i < 8; i++)
			push_access(KIND_READ, reg_off_t'(i), 16'($urandom));
		push_access(KIND_WRITE, REG_DATA, 16'hFFFF);
		push_access(KIND_WRITE, REG_ERROR, 16'hFFFF);
		push_access(KIND_WRITE, REG_COUNT, 16'hFF00);
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_READ});
		push_access(KIND_READ, REG_ERROR, 16'h0000);
		push_access(KIND_WRITE, REG_STATUS, {8'hFF, CMD_FLUSH});
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_IDENTIFY});
		push_access(KIND_READ, REG_ERROR, 16'hFFFF);
		push_access(KIND_WRITE, REG_DRIVE, 16'hFFFF);
		push_access(KIND_WRITE, REG_LBA_LOW, 16'hFF3F);
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_WRITE});
		push_access(KIND_WRITE, REG_DRIVE, 16'h00E0);
		push_access(KIND_WRITE, REG_COUNT, 16'h0001);
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_WRITE});
		push_access(KIND_READ, REG_STATUS, 16'h0000);
		push_access(KIND_READ, REG_DATA, 16'h0000);
		push_access(KIND_WRITE, REG_DATA, 16'hFFFF);
		push_access(KIND_WRITE, REG_DATA, 16'h0000);
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_FLUSH});
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_READ});
		push_access(KIND_READ, REG_DATA, 16'h0000);
		push_access(KIND_WRITE, REG_DATA, 16'h5A5A);
		push_access(KIND_READ, REG_DATA, 16'hFFFF);
		push_access(KIND_WRITE, REG_STATUS, {8'h00, CMD_FLUSH});

		while (pending.size() < 1730) begin
			choice = $urandom_range(99);
			full_q.delete();
			for (int s = 0; s < DISK_SECTORS; s++)
				if (disk_written[s * WORDS_PER_SECTOR])
					full_q.push_back(s);
			if (choice >= 45 && choice < 75 && full_q.size() > 0) begin
				lba = full_q[$urandom_range(full_q.size() - 1)];
				n   = 1;
				if (lba + 1 < DISK_SECTORS && disk_written[(lba + 1) * WORDS_PER_SECTOR] &&
						$urandom_range(99) < 20)
					n = 2;
				transfer(CMD_READ, lba, n);
			end else if (choice < 75) begin
				lba = $urandom_range(DISK_SECTORS - 1);
				n   = ($urandom_range(99) < 15 && lba + 2 <= DISK_SECTORS) ? 2 : 1;
				transfer(CMD_WRITE, lba, n);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					kind = 1'($urandom);
					off  = reg_off_t'($urandom_range(7));
					wd   = 16'($urandom);
					if (kind == KIND_WRITE && off == REG_STATUS && $urandom_range(2) == 0) begin
						case ($urandom_range(2))
							0:       wd[7:0] = CMD_READ;
							1:       wd[7:0] = CMD_WRITE;
							default: wd[7:0] = CMD_FLUSH;
						endcase
					end
					push_access(kind, off, wd);
				end
			end
		end
		total_items = pending.size();

		wait (arst_n);
		while (pending.size() != 0 || expected_rd.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ata_pio_task_file_disk] OK");
		else
			$display("[ata_pio_task_file_disk] ERROR");
		$finish;
	end

	function automatic int idle_pct(input bit sender);
		if (n_sent * 3 < total_items)
			return sender ? 24 : 83;
		else if (n_sent * 3 < total_items * 2)
			return sender ? 83 : 24;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_access_t done;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				done = pending.pop_front();
				expected_rd.push_back(done.rdata);
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending[0].wdata;
					s_tuser  <= {pending[0].off, pending[0].kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_rd.size() == 0) begin
					$error("read_data: no item expected, actual %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_rd.pop_front();
					if (m_tdata !== want) begin
						$error("read_data: expected %h, actual %h", want, m_tdata);
						fail_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	always @(posedge clk) begin
		int stall_cycles;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[ata_pio_task_file_disk] ERROR");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

endmodule

// ===== sim.f =====
rtl/core/atapio_pkg.sv
rtl/core/atapio_ram.sv
rtl/core/atapio_ctrl.sv
rtl/core/ata_pio_task_file_disk.sv
dv/tb_ata_pio_task_file_disk.sv
